// File: rtl/core/sac_pkg.sv
`default_nettype none

package sac_pkg;

   localparam int unsigned MAX_SERVO_ID = 24;
   localparam int unsigned MAX_DIGITS   = 5;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int unsigned QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCW   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_ID    = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;

   localparam logic [2:0] MODE_RAW     = 3'd0;
   localparam logic [2:0] MODE_CHECKED = 3'd1;
   localparam logic [2:0] MODE_180     = 3'd2;
   localparam logic [2:0] MODE_270     = 3'd3;

   localparam logic [15:0] PULSE_MIN = 16'd500;
   localparam logic [15:0] PULSE_MAX = 16'd2500;
   localparam logic [15:0] RANGE_180 = 16'd180;
   localparam logic [15:0] RANGE_270 = 16'd270;

   // 2000*a/180 = 100*a/9, 2000*a/270 = 200*a/27
   localparam logic [15:0] SCALE_180 = 16'd100;
   localparam logic [15:0] SCALE_270 = 16'd200;
   localparam logic [15:0] DIV_180   = 16'd9;
   localparam logic [15:0] DIV_270   = 16'd27;
   localparam logic [15:0] REC_180   = 16'd7281;
   localparam logic [15:0] REC_270   = 16'd2427;
   localparam logic [15:0] REC_10    = 16'd52429;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [3:0] CH_ZERO_HI = 4'h3;

   typedef struct packed {
      logic [4:0]  servo_id;
      logic [2:0]  mode;
      logic [15:0] angle;
      logic [15:0] move_time;
      logic [15:0] after_delay;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  error_code;
      logic [4:0]  servo_id;
      logic [15:0] pulse;
      logic [15:0] move_time;
      logic [15:0] after_delay;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_FIX
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ERR,
      B_PREFIX,
      B_CONV,
      B_DIGIT,
      B_CR,
      B_LF
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/core/sac_front.sv
`default_nettype none

module sac_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sac_pkg::req_type req_data,
   output logic             cmd_push,
   input  logic             cmd_full,
   output sac_pkg::cmd_type cmd_data
);

   sac_pkg::front_state_type state_ff, state_in;
   sac_pkg::req_type req_ff;
   logic [1:0]  err_ff, err_in;
   logic [15:0] num_ff, num_in;
   logic [31:0] prod_ff;
   logic        accept;
   logic        id_bad, mode_bad, range_bad;
   logic [15:0] q0, q9, q27, rem, div, quot, pulse;

   assign accept = req_push && !req_full;

   always_comb begin
      id_bad   = {3'b000, req_data.servo_id} > 8'(sac_pkg::MAX_SERVO_ID);
      mode_bad = req_data.mode > sac_pkg::MODE_270;
      case (req_data.mode)
         sac_pkg::MODE_CHECKED: range_bad = (req_data.angle < sac_pkg::PULSE_MIN) ||
                                            (req_data.angle > sac_pkg::PULSE_MAX);
         sac_pkg::MODE_180:     range_bad = req_data.angle > sac_pkg::RANGE_180;
         sac_pkg::MODE_270:     range_bad = req_data.angle > sac_pkg::RANGE_270;
         default:               range_bad = 1'b0;
      endcase
      if (id_bad || mode_bad) begin
         err_in = sac_pkg::ERR_ID;
      end else if (range_bad) begin
         err_in = sac_pkg::ERR_RANGE;
      end else begin
         err_in = sac_pkg::ERR_NONE;
      end
      if (req_data.mode == sac_pkg::MODE_270) begin
         num_in = 16'(32'(req_data.angle) * 32'(sac_pkg::SCALE_270));
      end else begin
         num_in = 16'(32'(req_data.angle) * 32'(sac_pkg::SCALE_180));
      end
   end

   // next state
   always_comb begin
      case (state_ff)
         sac_pkg::F_IDLE: state_in = accept ? sac_pkg::F_MUL : sac_pkg::F_IDLE;
         sac_pkg::F_MUL:  state_in = sac_pkg::F_FIX;
         sac_pkg::F_FIX:  state_in = cmd_full ? sac_pkg::F_FIX : sac_pkg::F_IDLE;
         default:         state_in = sac_pkg::F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      case (state_ff)
         sac_pkg::F_IDLE: begin
            req_full = 1'b0;
            cmd_push = 1'b0;
         end
         sac_pkg::F_FIX: begin
            req_full = 1'b1;
            cmd_push = !cmd_full;
         end
         default: begin
            req_full = 1'b1;
            cmd_push = 1'b0;
         end
      endcase
   end

   // quotient estimate is exact or one low
   always_comb begin
      q0  = prod_ff[31:16];
      q9  = (q0 << 3) + q0;
      q27 = (q0 << 4) + (q0 << 3) + (q0 << 1) + q0;
      if (req_ff.mode == sac_pkg::MODE_270) begin
         div = sac_pkg::DIV_270;
         rem = num_ff - q27;
      end else begin
         div = sac_pkg::DIV_180;
         rem = num_ff - q9;
      end
      quot = q0 + ((rem >= div) ? 16'd1 : 16'd0);
      if ((req_ff.mode == sac_pkg::MODE_180) || (req_ff.mode == sac_pkg::MODE_270)) begin
         pulse = sac_pkg::PULSE_MIN + quot;
      end else begin
         pulse = req_ff.angle;
      end
      cmd_data.error_code  = err_ff;
      cmd_data.servo_id    = req_ff.servo_id;
      cmd_data.pulse       = pulse;
      cmd_data.move_time   = req_ff.move_time;
      cmd_data.after_delay = req_ff.after_delay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sac_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
         err_ff <= err_in;
         num_ff <= num_in;
      end
      if (state_ff == sac_pkg::F_MUL) begin
         if (req_ff.mode == sac_pkg::MODE_270) begin
            prod_ff <= 32'(num_ff) * 32'(sac_pkg::REC_270);
         end else begin
            prod_ff <= 32'(num_ff) * 32'(sac_pkg::REC_180);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/sac_queue.sv
`default_nettype none

module sac_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sac_pkg::cmd_type push_data,
   output logic             valid,
   input  logic             pop,
   output sac_pkg::cmd_type pop_data
);

   sac_pkg::cmd_type mem_ff [sac_pkg::QUEUE_DEPTH];
   logic [sac_pkg::QPW-1:0] wr_ff, rd_ff;
   logic [sac_pkg::QCW-1:0] cnt_ff;
   logic do_push, do_pop;

   assign full     = cnt_ff == sac_pkg::QCW'(sac_pkg::QUEUE_DEPTH);
   assign valid    = cnt_ff != '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == sac_pkg::QPW'(sac_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == sac_pkg::QPW'(sac_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/sac_back.sv
`default_nettype none

module sac_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  sac_pkg::cmd_type cmd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sac_pkg::rsp_type rsp_data
);

   sac_pkg::back_state_type state_ff, state_in;
   sac_pkg::cmd_type cmd_ff;
   sac_pkg::rsp_type out_ff, emit_data;
   logic        out_vld_ff;
   logic        out_ready, emit;
   logic [1:0]  field_ff, field_in;
   logic [15:0] val_ff, val_in, field_val, quot10, rem10;
   logic [31:0] prod10;
   logic [3:0]  dig_ff [sac_pkg::MAX_DIGITS];
   logic [3:0]  dig_in [sac_pkg::MAX_DIGITS];
   logic [sac_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic        conv_done;
   logic [7:0]  letter;

   assign out_ready = !out_vld_ff || rsp_pop;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (field_ff)
         2'd0: begin
            field_val = {11'd0, cmd_ff.servo_id};
            letter    = sac_pkg::CH_HASH;
         end
         2'd1: begin
            field_val = cmd_ff.pulse;
            letter    = sac_pkg::CH_P;
         end
         2'd2: begin
            field_val = cmd_ff.move_time;
            letter    = sac_pkg::CH_T;
         end
         default: begin
            field_val = cmd_ff.after_delay;
            letter    = sac_pkg::CH_D;
         end
      endcase
      // exact v/10 for 16-bit v
      prod10    = 32'(val_ff) * 32'(sac_pkg::REC_10);
      quot10    = 16'(prod10 >> 19);
      rem10     = val_ff - ((quot10 << 3) + (quot10 << 1));
      conv_done = (quot10 == 16'd0) ||
                  (cnt_ff == sac_pkg::CNT_W'(sac_pkg::MAX_DIGITS - 1));
   end

   // next state
   always_comb begin
      case (state_ff)
         sac_pkg::B_IDLE: begin
            if (!cmd_valid) begin
               state_in = sac_pkg::B_IDLE;
            end else if (cmd_data.error_code != sac_pkg::ERR_NONE) begin
               state_in = sac_pkg::B_ERR;
            end else begin
               state_in = sac_pkg::B_PREFIX;
            end
         end
         sac_pkg::B_ERR:    state_in = out_ready ? sac_pkg::B_IDLE : sac_pkg::B_ERR;
         sac_pkg::B_PREFIX: state_in = out_ready ? sac_pkg::B_CONV : sac_pkg::B_PREFIX;
         sac_pkg::B_CONV:   state_in = conv_done ? sac_pkg::B_DIGIT : sac_pkg::B_CONV;
         sac_pkg::B_DIGIT: begin
            if (out_ready && (cnt_ff == sac_pkg::CNT_W'(1))) begin
               state_in = (field_ff == 2'd3) ? sac_pkg::B_CR : sac_pkg::B_PREFIX;
            end else begin
               state_in = sac_pkg::B_DIGIT;
            end
         end
         sac_pkg::B_CR:     state_in = out_ready ? sac_pkg::B_LF : sac_pkg::B_CR;
         sac_pkg::B_LF:     state_in = out_ready ? sac_pkg::B_IDLE : sac_pkg::B_LF;
         default:           state_in = sac_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop   = 1'b0;
      emit      = 1'b0;
      emit_data = '0;
      case (state_ff)
         sac_pkg::B_IDLE: begin
            cmd_pop = cmd_valid;
         end
         sac_pkg::B_ERR: begin
            emit                 = out_ready;
            emit_data.last_byte  = 1'b1;
            emit_data.error_code = cmd_ff.error_code;
         end
         sac_pkg::B_PREFIX: begin
            emit               = out_ready;
            emit_data.out_byte = letter;
         end
         sac_pkg::B_DIGIT: begin
            emit               = out_ready;
            emit_data.out_byte = {sac_pkg::CH_ZERO_HI, dig_ff[0]};
         end
         sac_pkg::B_CR: begin
            emit               = out_ready;
            emit_data.out_byte = sac_pkg::CH_CR;
         end
         sac_pkg::B_LF: begin
            emit                = out_ready;
            emit_data.out_byte  = sac_pkg::CH_LF;
            emit_data.last_byte = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // digit datapath: shift in low digit first, shift out from the top
   always_comb begin
      field_in = field_ff;
      val_in   = val_ff;
      cnt_in   = cnt_ff;
      for (int i = 0; i < sac_pkg::MAX_DIGITS; i++) begin
         dig_in[i] = dig_ff[i];
      end
      case (state_ff)
         sac_pkg::B_IDLE: begin
            field_in = 2'd0;
         end
         sac_pkg::B_PREFIX: begin
            val_in = field_val;
            cnt_in = '0;
         end
         sac_pkg::B_CONV: begin
            val_in    = quot10;
            cnt_in    = cnt_ff + 1'b1;
            dig_in[0] = rem10[3:0];
            for (int i = 1; i < sac_pkg::MAX_DIGITS; i++) begin
               dig_in[i] = dig_ff[i-1];
            end
         end
         sac_pkg::B_DIGIT: begin
            if (out_ready) begin
               cnt_in = cnt_ff - 1'b1;
               for (int i = 0; i < sac_pkg::MAX_DIGITS - 1; i++) begin
                  dig_in[i] = dig_ff[i+1];
               end
               dig_in[sac_pkg::MAX_DIGITS-1] = 4'd0;
               if (cnt_ff == sac_pkg::CNT_W'(1)) begin
                  field_in = field_ff + 2'd1;
               end
            end
         end
         default: begin
            field_in = field_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sac_pkg::B_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (emit) begin
         out_ff <= emit_data;
      end
      field_ff <= field_in;
      val_ff   <= val_in;
      cnt_ff   <= cnt_in;
      for (int i = 0; i < sac_pkg::MAX_DIGITS; i++) begin
         dig_ff[i] <= dig_in[i];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/servo_ascii_command_encoder_core.sv
`default_nettype none

// Servo move request in, ASCII command "#<id>P<pulse>T<time>D<delay>\r\n" out, one byte per
// response, last byte flagged; a rejected request gives a single zero byte with its error
// code. The front checks a request and scales the angle, then hands it through a 2-entry
// queue to the back, which converts each number one decimal digit per cycle and then sends
// the digits one per cycle while rsp_pop keeps the output free. The front takes a new request
// only once the last one is in the queue, and the back takes the next command only after it
// has sent the last byte of the one before.
module servo_ascii_command_encoder_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sac_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sac_pkg::rsp_type rsp_data
);

   logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
   sac_pkg::cmd_type cmd_in, cmd_out;

   sac_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in)
   );

   sac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (cmd_in),
      .valid     (cmd_valid),
      .pop       (cmd_pop),
      .pop_data  (cmd_out)
   );

   sac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
